@@ hdl/rtvk_pkg.sv @@
// rtvk_pkg: widths, constants and shared types of the radial trap velocity kick
// no dependencies; imported by every module of the block
package rtvk_pkg;

    localparam int DW          = 32;                       // data word, signed q16.16
    localparam int FRAC_BITS   = 16;
    localparam int RAD_W       = DW - 1;                   // radius width
    localparam int DXW         = DW + 1;                   // offset width
    localparam int MAGW        = DW;                       // offset magnitude when captured
    localparam int D2W         = 2 * RAD_W;                // squared distance when captured
    localparam int ROOT_W      = RAD_W;                    // distance width
    localparam int SQRT_STAGES = ROOT_W;
    localparam int SQ_REM_W    = ROOT_W + 2;
    localparam int CSQ_W       = D2W - FRAC_BITS;          // clamped squared distance
    localparam int NUM_W       = MAGW + FRAC_BITS;         // dividend width
    localparam int QW          = DW + 1;                   // quotient width
    localparam int DIV_STEPS   = QW;
    localparam int UNIT_W      = FRAC_BITS + 1;            // unit offset, at most 1.0
    localparam int PROD_W      = NUM_W;
    localparam int TDATA_W     = 2 * DW;
    localparam int IN_W        = 4 * DW;

    localparam logic [CSQ_W-1:0] CLAMP_SQ =
        CSQ_W'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);

    typedef enum logic [1:0] {
        REG_TRAP_X   = 2'd0,
        REG_TRAP_Y   = 2'd1,
        REG_STRENGTH = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg_idx;

    // per-item side data carried alongside the arithmetic units
    typedef struct packed {
        logic                   valid;
        logic                   cap;
        logic signed [DW-1:0]   vx;
        logic signed [DW-1:0]   vy;
        logic                   negx;
        logic                   negy;
        logic                   zx;
        logic                   zy;
        logic [MAGW-1:0]        magx;
        logic [MAGW-1:0]        magy;
        logic [CSQ_W-1:0]       csq;
    } t_side;

endpackage

@@ hdl/radial_trap_velocity_kick_top.sv @@
// radial_trap_velocity_kick_top: trap kick pipeline, config registers and stream ports
// depends on rtvk_pkg, rtvk_isqrt, rtvk_div
//
// channel   dir  handshake               payload
// s         in   i_s_tvalid/o_s_tready   tdata: ball_x, ball_y, vel_x, vel_y
// m         out  o_m_tvalid/i_m_tready   tdata: new_vel_x, new_vel_y; tuser: captured
// cfg       in   i_cfg_we                i_cfg_idx, i_cfg_data
//
// one beat per cycle while the output is not stalled; the path runs through the 31-stage square root
// and the two 33-stage dividers in series
// synchronous active-low reset clears the config registers and all valid bits
// the whole pipeline holds while the output register is full and not taken
module radial_trap_velocity_kick_top import rtvk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [IN_W-1:0]     i_s_tdata,   // ball_x, ball_y, vel_x, vel_y
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [TDATA_W-1:0]  o_m_tdata,   // new_vel_x, new_vel_y
    output logic                o_m_tuser,   // captured
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [DW-1:0]       i_cfg_data
);

    // config registers
    logic signed [DW-1:0] r_trap_x, r_trap_y, r_strength;
    logic [RAD_W-1:0]     r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trap_x   <= '0;
            r_trap_y   <= '0;
            r_strength <= '0;
            r_radius   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TRAP_X:   r_trap_x   <= i_cfg_data;
                REG_TRAP_Y:   r_trap_y   <= i_cfg_data;
                REG_STRENGTH: r_strength <= i_cfg_data;
                REG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // the user must keep strength static while items are in flight; the block does not enforce it
    logic [DW-1:0] w_s_mag;
    logic          w_s_neg, w_s_zero;
    assign w_s_neg  = r_strength[DW-1];
    assign w_s_zero = (r_strength == '0);
    assign w_s_mag  = w_s_neg ? DW'(-r_strength) : DW'(r_strength);

    // global advance: move when the output slot is free or being taken
    logic r_out_valid;
    logic w_en;
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // stage a: offsets
    logic                  r_a_valid;
    logic signed [DXW-1:0] r_a_dx, r_a_dy;
    logic signed [DW-1:0]  r_a_vx, r_a_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx <= DXW'(r_trap_x) - DXW'($signed(i_s_tdata[DW-1:0]));
            r_a_dy <= DXW'(r_trap_y) - DXW'($signed(i_s_tdata[2*DW-1:DW]));
            r_a_vx <= i_s_tdata[3*DW-1:2*DW];
            r_a_vy <= i_s_tdata[4*DW-1:3*DW];
        end
    end

    // stage b: squares and radius squared
    logic [DXW-1:0]     w_b_magx, w_b_magy;
    logic               r_b_valid;
    logic [2*DXW-1:0]   r_b_sqx, r_b_sqy;
    logic [D2W-1:0]     r_b_r2;
    logic [DXW-1:0]     r_b_magx, r_b_magy;
    logic               r_b_negx, r_b_negy;
    logic signed [DW-1:0] r_b_vx, r_b_vy;

    assign w_b_magx = r_a_dx[DXW-1] ? DXW'(-r_a_dx) : DXW'(r_a_dx);
    assign w_b_magy = r_a_dy[DXW-1] ? DXW'(-r_a_dy) : DXW'(r_a_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_sqx  <= w_b_magx * w_b_magx;
            r_b_sqy  <= w_b_magy * w_b_magy;
            r_b_r2   <= r_radius * r_radius;
            r_b_magx <= w_b_magx;
            r_b_magy <= w_b_magy;
            r_b_negx <= r_a_dx[DXW-1];
            r_b_negy <= r_a_dy[DXW-1];
            r_b_vx   <= r_a_vx;
            r_b_vy   <= r_a_vy;
        end
    end

    // stage c: squared distance, capture test, clamped square
    logic [2*DXW:0]   w_c_d2;
    logic             w_c_cap;
    logic [CSQ_W-1:0] w_c_csq;
    logic [D2W-1:0]   r_c_d2;
    t_side            r_c_side;
    t_side            n_c_side;

    assign w_c_d2  = {1'b0, r_b_sqx} + {1'b0, r_b_sqy};
    assign w_c_cap = w_c_d2 <= (2*DXW+1)'(r_b_r2);
    assign w_c_csq = (w_c_d2[D2W-1:FRAC_BITS] < CLAMP_SQ) ? CLAMP_SQ
                                                         : w_c_d2[D2W-1:FRAC_BITS];

    always_comb begin
        n_c_side.valid = r_b_valid;
        n_c_side.cap   = w_c_cap;
        n_c_side.vx    = r_b_vx;
        n_c_side.vy    = r_b_vy;
        n_c_side.negx  = r_b_negx;
        n_c_side.negy  = r_b_negy;
        n_c_side.zx    = (r_b_magx == '0);
        n_c_side.zy    = (r_b_magy == '0);
        // magnitudes stay below 2^31 whenever the ball is captured
        n_c_side.magx  = r_b_magx[MAGW-1:0];
        n_c_side.magy  = r_b_magy[MAGW-1:0];
        n_c_side.csq   = w_c_csq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side <= '0;
        end else if (w_en) begin
            r_c_side <= n_c_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_d2 <= w_c_d2[D2W-1:0];
        end
    end

    // square root, side data delayed alongside
    logic [ROOT_W-1:0] w_dist;
    t_side             r_d1 [SQRT_STAGES];

    rtvk_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_c_d2),
        .o_root (w_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQRT_STAGES; i++) r_d1[i] <= '0;
        end else if (w_en) begin
            r_d1[0] <= r_c_side;
            for (int i = 1; i < SQRT_STAGES; i++) r_d1[i] <= r_d1[i-1];
        end
    end

    // unit offsets: |d| * 2^16 / dist
    t_side          w_s1;
    logic [QW-1:0]  w_unitx, w_unity;
    t_side          r_d2 [DIV_STEPS];

    assign w_s1 = r_d1[SQRT_STAGES-1];

    rtvk_div u_div_ux (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({w_s1.magx, {FRAC_BITS{1'b0}}}),
        .i_den (CSQ_W'(w_dist)),
        .o_quo (w_unitx)
    );

    rtvk_div u_div_uy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({w_s1.magy, {FRAC_BITS{1'b0}}}),
        .i_den (CSQ_W'(w_dist)),
        .o_quo (w_unity)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STEPS; i++) r_d2[i] <= '0;
        end else if (w_en) begin
            r_d2[0] <= w_s1;
            for (int i = 1; i < DIV_STEPS; i++) r_d2[i] <= r_d2[i-1];
        end
    end

    // stage m: |strength| * unit
    logic [PROD_W-1:0] r_m_px, r_m_py;
    t_side             r_m_side;
    logic [DW+UNIT_W-1:0] w_m_px, w_m_py;

    assign w_m_px = w_s_mag * w_unitx[UNIT_W-1:0];
    assign w_m_py = w_s_mag * w_unity[UNIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_side <= '0;
        end else if (w_en) begin
            r_m_side <= r_d2[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_px <= w_m_px[PROD_W-1:0];
            r_m_py <= w_m_py[PROD_W-1:0];
        end
    end

    // kick magnitudes: product / clamped square
    logic [QW-1:0] w_qx, w_qy;
    t_side         r_d4 [DIV_STEPS];

    rtvk_div u_div_kx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_m_px),
        .i_den (r_m_side.csq),
        .o_quo (w_qx)
    );

    rtvk_div u_div_ky (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_m_py),
        .i_den (r_m_side.csq),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STEPS; i++) r_d4[i] <= '0;
        end else if (w_en) begin
            r_d4[0] <= r_m_side;
            for (int i = 1; i < DIV_STEPS; i++) r_d4[i] <= r_d4[i-1];
        end
    end

    // output stage: cap, sign, saturating add
    t_side                 w_f;
    logic [QW-1:0]         w_kmx, w_kmy;
    logic signed [QW:0]    w_kx, w_ky;
    logic signed [QW+1:0]  w_sx, w_sy;
    logic signed [DW-1:0]  w_nvx, w_nvy;
    logic signed [QW+1:0]  w_max, w_min;
    logic [DW-1:0]         r_out_vx, r_out_vy;
    logic                  r_out_cap;

    assign w_f   = r_d4[DIV_STEPS-1];
    assign w_max = (QW+2)'({1'b0, {(DW-1){1'b1}}});
    assign w_min = -(QW+2)'({1'b1, {(DW-1){1'b0}}});

    always_comb begin
        // anything at or above 2^32 caps to 2^32
        w_kmx = w_qx[QW-1] ? {1'b1, {(QW-1){1'b0}}} : w_qx;
        w_kmy = w_qy[QW-1] ? {1'b1, {(QW-1){1'b0}}} : w_qy;
        if (w_f.zx || w_s_zero) begin
            w_kx = '0;
        end else if (w_s_neg != w_f.negx) begin
            w_kx = -$signed({1'b0, w_kmx});
        end else begin
            w_kx = $signed({1'b0, w_kmx});
        end
        if (w_f.zy || w_s_zero) begin
            w_ky = '0;
        end else if (w_s_neg != w_f.negy) begin
            w_ky = -$signed({1'b0, w_kmy});
        end else begin
            w_ky = $signed({1'b0, w_kmy});
        end
        w_sx = (QW+2)'(w_f.vx) + (QW+2)'(w_kx);
        w_sy = (QW+2)'(w_f.vy) + (QW+2)'(w_ky);
        if (w_sx > w_max)      w_nvx = w_max[DW-1:0];
        else if (w_sx < w_min) w_nvx = w_min[DW-1:0];
        else                   w_nvx = w_sx[DW-1:0];
        if (w_sy > w_max)      w_nvy = w_max[DW-1:0];
        else if (w_sy < w_min) w_nvy = w_min[DW-1:0];
        else                   w_nvy = w_sy[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_f.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // outside the radius the velocity passes through untouched
            r_out_vx  <= w_f.cap ? w_nvx : w_f.vx;
            r_out_vy  <= w_f.cap ? w_nvy : w_f.vy;
            r_out_cap <= w_f.cap;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_vy, r_out_vx};
    assign o_m_tuser  = r_out_cap;

endmodule

@@ hdl/rtvk_isqrt.sv @@
// rtvk_isqrt: pipelined integer square root, one result bit per stage
// depends on rtvk_pkg
module rtvk_isqrt import rtvk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [D2W-1:0]     i_rad,
    output logic [ROOT_W-1:0]  o_root
);

    logic [SQ_REM_W-1:0] r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]   r_root [SQRT_STAGES];
    logic [D2W-1:0]      r_rad  [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic [SQ_REM_W-1:0] c_rem;
            logic [ROOT_W-1:0]   c_root;
            logic [D2W-1:0]      c_rad;
            logic [SQ_REM_W+1:0] c_t;
            logic [SQ_REM_W+1:0] c_trial;
            logic [SQ_REM_W-1:0] n_rem;
            logic [ROOT_W-1:0]   n_root;

            if (k == 0) begin : g_first
                assign c_rem  = '0;
                assign c_root = '0;
                assign c_rad  = i_rad;
            end else begin : g_next
                assign c_rem  = r_rem[k-1];
                assign c_root = r_root[k-1];
                assign c_rad  = r_rad[k-1];
            end

            always_comb begin
                c_t     = {c_rem, c_rad[D2W-1 -: 2]};
                c_trial = {2'b00, c_root, 2'b01};
                if (c_t >= c_trial) begin
                    n_rem  = SQ_REM_W'(c_t - c_trial);
                    n_root = {c_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = c_t[SQ_REM_W-1:0];
                    n_root = {c_root[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_rad[k]  <= {c_rad[D2W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

@@ hdl/rtvk_div.sv @@
// rtvk_div: pipelined restoring divider, one quotient bit per stage
// depends on rtvk_pkg; needs i_num / 2^QW below i_den
module rtvk_div import rtvk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [CSQ_W-1:0]  i_den,
    output logic [QW-1:0]     o_quo
);

    logic [CSQ_W-1:0] r_rem [DIV_STEPS];
    logic [QW-1:0]    r_nb  [DIV_STEPS];
    logic [CSQ_W-1:0] r_den [DIV_STEPS];
    logic [QW-1:0]    r_quo [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [CSQ_W-1:0] c_rem;
            logic [QW-1:0]    c_nb;
            logic [CSQ_W-1:0] c_den;
            logic [QW-1:0]    c_quo;
            logic [CSQ_W:0]   c_t;
            logic             c_ge;
            logic [CSQ_W-1:0] n_rem;

            if (k == 0) begin : g_first
                assign c_rem = CSQ_W'(i_num[NUM_W-1:QW]);
                assign c_nb  = i_num[QW-1:0];
                assign c_den = i_den;
                assign c_quo = '0;
            end else begin : g_next
                assign c_rem = r_rem[k-1];
                assign c_nb  = r_nb[k-1];
                assign c_den = r_den[k-1];
                assign c_quo = r_quo[k-1];
            end

            always_comb begin
                c_t  = {c_rem, c_nb[QW-1]};
                c_ge = c_t >= {1'b0, c_den};
                if (c_ge) begin
                    n_rem = CSQ_W'(c_t - {1'b0, c_den});
                end else begin
                    n_rem = c_t[CSQ_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_nb[k]  <= {c_nb[QW-2:0], 1'b0};
                    r_den[k] <= c_den;
                    r_quo[k] <= {c_quo[QW-2:0], c_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

@@ tb/trap_kick_checker.sv @@
`timescale 1ns / 1ps
// trap_kick_checker: watches the input, output and config channels of the trap kick block
// predicts each velocity kick bit-exactly and compares; depends on rtvk_pkg
module trap_kick_checker import rtvk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [IN_W-1:0]     i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [TDATA_W-1:0]  i_m_tdata,
    input  logic                i_m_tuser,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [DW-1:0]       i_cfg_data,
    output int                  o_fail_cnt,
    output int                  o_pending,
    output int                  o_beats,
    output int                  o_captured
);

    typedef struct packed {
        logic [DW-1:0] vx;
        logic [DW-1:0] vy;
        logic          cap;
    } t_kick_res;

    t_kick_res      kick_q[$];
    logic [DW-1:0]  trap_x, trap_y, strength;
    logic [RAD_W-1:0] radius;

    assign o_pending = kick_q.size();

    task automatic report(input string what, input logic [DW-1:0] got, input logic [DW-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        o_fail_cnt++;
    endtask

    // one axis: strength * (off / distance) / csq, truncated toward zero, capped at 2^DW
    function automatic longint axis_kick(input longint f, input longint off,
                                         input logic [127:0] d_root, input logic [127:0] csq);
        logic [127:0] unit, q, k;
        longint mf, mo;
        mf = (f < 0) ? -f : f;
        mo = (off < 0) ? -off : off;
        if (off == 0 || f == 0) return 0;
        unit = (128'(mo) << FRAC_BITS) / d_root;
        q    = (128'(mf) * unit) / csq;
        k    = (q > (128'd1 << DW)) ? (128'd1 << DW) : q;
        return ((f < 0) != (off < 0)) ? -longint'(k) : longint'(k);
    endfunction

    function automatic logic [DW-1:0] sat_add(input longint v, input longint k);
        longint s;
        s = v + k;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[DW-1:0];
    endfunction

    function automatic t_kick_res predict_kick(input logic [IN_W-1:0] d);
        longint dx, dy, vx, vy, mx, my, f;
        logic [127:0] d2, r2, root, c, csq;
        t_kick_res r;
        dx = longint'($signed(trap_x)) - longint'($signed(d[31:0]));
        dy = longint'($signed(trap_y)) - longint'($signed(d[63:32]));
        vx = longint'($signed(d[95:64]));
        vy = longint'($signed(d[127:96]));
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        d2 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        r2 = 128'(radius) * 128'(radius);
        if (d2 > r2) begin
            r.vx = d[95:64]; r.vy = d[127:96]; r.cap = 1'b0;
            return r;
        end
        r.cap = 1'b1;
        if (d2 == 0) begin
            // ball sits on the centre: no kick
            r.vx = d[95:64]; r.vy = d[127:96];
            return r;
        end
        root = 0;
        for (int b = 33; b >= 0; b--) begin
            c = root | (128'd1 << b);
            if (c * c <= d2) root = c;
        end
        csq = d2 >> FRAC_BITS;
        if (csq < 128'(CLAMP_SQ)) csq = 128'(CLAMP_SQ);
        f = longint'($signed(strength));
        r.vx = sat_add(vx, axis_kick(f, dx, root, csq));
        r.vy = sat_add(vy, axis_kick(f, dy, root, csq));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_kick_res want;
        if (!i_rst_n) begin
            trap_x <= '0; trap_y <= '0; strength <= '0; radius <= '0;
        end else begin
            // predict with the config in force before this edge's write
            if (i_s_tvalid && i_s_tready) begin
                kick_q.push_back(predict_kick(i_s_tdata));
                o_beats++;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (kick_q.size() == 0) begin
                    $display("unexpected output beat at %0t", $realtime);
                    o_fail_cnt++;
                end else begin
                    want = kick_q.pop_front();
                    if (i_m_tdata[31:0] !== want.vx) report("new_vel_x", i_m_tdata[31:0], want.vx);
                    if (i_m_tdata[63:32] !== want.vy) report("new_vel_y", i_m_tdata[63:32], want.vy);
                    if (i_m_tuser !== want.cap) report("captured", 32'(i_m_tuser), 32'(want.cap));
                    if (want.cap) o_captured++;
                end
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_TRAP_X:   trap_x   <= i_cfg_data;
                    REG_TRAP_Y:   trap_y   <= i_cfg_data;
                    REG_STRENGTH: strength <= i_cfg_data;
                    REG_RADIUS:   radius   <= i_cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    initial begin
        o_fail_cnt = 0;
        o_beats    = 0;
        o_captured = 0;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: stimulus and verdict for radial_trap_velocity_kick_top
// depends on rtvk_pkg, the block and trap_kick_checker
module testbench;
    import rtvk_pkg::*;

    localparam int DRAIN_CYC  = 120;
    localparam int CYC_LIMIT  = 400000;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 142;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [DW-1:0]      cfg_data;

    int fail_cnt, pending, beats, captured;
    int tx_idle_pct, rx_stall_pct;
    int cyc;
    logic [DW-1:0] cur_trap_x, cur_trap_y;

    radial_trap_velocity_kick_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // ball_x, ball_y, vel_x, vel_y
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),     // new_vel_x, new_vel_y
        .o_m_tuser  (m_tuser),     // captured
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    trap_kick_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_beats    (beats),
        .o_captured (captured)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver stalls at random, at the rate of the current phase
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("status: fail");
            $finish;
        end
    end

    // one input beat; idle gaps before it drop tvalid
    task automatic send_ball(input logic [DW-1:0] bx, input logic [DW-1:0] by,
                             input logic [DW-1:0] vx, input logic [DW-1:0] vy);
        logic rdy;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx, by, bx};
        // ready is stable between the falling edge and the next rising edge
        do begin
            @(negedge i_clk);
            rdy = s_tready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // wait until every kick is back, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // write all four registers, enable held high across the run of writes
    task automatic load_trap(input logic [DW-1:0] tx, input logic [DW-1:0] ty,
                             input logic [DW-1:0] st, input logic [DW-1:0] rad);
        logic [DW-1:0] vals [4];
        vals = '{tx, ty, st, rad};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= 2'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_trap_x = tx;
        cur_trap_y = ty;
    endtask

    // offset of random size, from tiny up to full scale
    function automatic logic [DW-1:0] rand_offset();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    initial begin
        cyc          = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_TRAP_X;
        cfg_data = '0;
        cur_trap_x = '0;
        cur_trap_y = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: radius zero, so only a ball on the origin is captured
        send_ball(32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
        send_ball(32'h1, 32'h0, 32'h1234_5678, 32'h0);
        send_ball(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        drain();

        // widest radius, strongest pull: saturation and clamped distance
        load_trap(32'h0001_0000, 32'hfffe_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_ball(32'h0001_0000, 32'hfffe_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_ball(32'h0000_0000, 32'hfffe_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_ball(32'h0002_0000, 32'hfffe_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_ball(32'h0001_0000, 32'hfffe_0001, 32'h0, 32'h0);
        send_ball(32'h0001_8000, 32'hfffd_8000, 32'h0, 32'h0);
        send_ball(32'h0021_0000, 32'h0030_0000, 32'h0100_0000, 32'hff00_0000);
        send_ball(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_ball(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
        drain();

        // most negative strength, trap at the corner, tiny radius
        load_trap(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_ball(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_ball(32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_ball(32'h8000_0000, 32'h7fff_fffe, 32'h0, 32'h0);
        send_ball(32'h8000_0002, 32'h7fff_ffff, 32'h0, 32'h0);
        send_ball(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
            endcase
            case (ph)
                0: load_trap(32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff);
                1: load_trap(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
                2: load_trap(32'h7fff_ffff, 32'h7fff_ffff, $urandom, $urandom >> 8);
                default: load_trap($urandom, $urandom, $urandom >> $urandom_range(0, 16),
                                   $urandom >> $urandom_range(1, 24));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 70)
                    // ball near the trap, mostly captured
                    send_ball(cur_trap_x - rand_offset(), cur_trap_y - rand_offset(),
                              $urandom, $urandom);
                else
                    send_ball($urandom, $urandom, $urandom, $urandom);
            end
            drain();
        end

        $display("%0d balls checked over %0d trap settings, %0d of them captured",
                 beats, PHASES + 3, captured);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("status: fail");
        end
        $finish;
    end

endmodule
